// ----- hw/rtl/hkf_pkg.sv -----
// Shared widths, constants and types of the heading Kalman filter.
package hkf_pkg;

  localparam int AngleW = 19;
  localparam int VarW   = 32;
  localparam int DistW  = 24;
  localparam int RateW  = 22;
  localparam int MeasW  = 19;
  localparam int TsW    = 16;
  localparam int NoiseW = 24;
  localparam int FracW  = 16;

  localparam int GainW   = FracW + 1;
  localparam int MulAW   = 32;
  localparam int MulBW   = GainW;
  localparam int MulPW   = MulAW + MulBW;
  localparam int DivDenW = VarW + 1;
  localparam int DivNumW = VarW + GainW;
  localparam int InnovW  = RateW;
  localparam int WrapW   = 23;

  localparam int InDataW  = 104;
  localparam int OutDataW = 80;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;

  localparam logic [AngleW-1:0] AnglePi  = 19'd205887;
  localparam logic [AngleW-1:0] AngleTwoPi = 19'd411775;
  localparam logic [GainW-1:0]  GainOne  = 17'd65536;
  localparam logic [MulPW-1:0]  RoundHalf = MulPW'(32768);
  localparam int WrapSteps = 4;
  localparam logic [WrapW:0] WrapBias = (WrapW + 1)'(411775 * (2 ** (WrapSteps - 1)));

  localparam logic [TsW-1:0]    ResetTimeStep  = 16'd655;
  localparam logic [NoiseW-1:0] ResetGyroNoise = 24'd73185;
  localparam logic [AngleW-1:0] ResetAngle     = 19'd205887;
  localparam logic [VarW-1:0]   ResetVariance  = 32'd7319750;

  localparam logic OpGyro = 1'b0;
  localparam logic OpRow  = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TIME_STEP  = 2'd0,
    CFG_GYRO_NOISE = 2'd1,
    CFG_INIT_ANGLE = 2'd2,
    CFG_INIT_VAR   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ----- hw/rtl/hkf_serial_mul.sv -----
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module hkf_serial_mul (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [hkf_pkg::MulAW-1:0] a,
  input  logic [hkf_pkg::MulBW-1:0] b,
  output logic [hkf_pkg::MulPW-1:0] product,
  output hkf_pkg::unit_stat_t       stat
);
  import hkf_pkg::*;

  localparam int CntW = $clog2(MulBW + 1);

  logic [MulPW-1:0] prod_r;
  logic [MulPW-1:0] prod_nxt;
  logic [MulAW-1:0] a_r;
  logic [CntW-1:0]  cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [MulAW:0]   sum;

  always_comb begin
    sum      = {1'b0, prod_r[MulPW-1:MulBW]} + (prod_r[0] ? {1'b0, a_r} : '0);
    prod_nxt = {sum, prod_r[MulBW-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CntW'(MulBW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r    <= a;
      prod_r <= {{MulAW{1'b0}}, b};
    end else if (busy_r) begin
      prod_r <= prod_nxt;
    end
  end

  assign product   = prod_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ----- hw/rtl/hkf_gain_div.sv -----
// Restoring divider for the Kalman gain, one quotient bit per cycle.
module hkf_gain_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [hkf_pkg::DivNumW-1:0] num,
  input  logic [hkf_pkg::DivDenW-1:0] den,
  output logic [hkf_pkg::GainW-1:0]   quotient,
  output hkf_pkg::unit_stat_t         stat
);
  import hkf_pkg::*;

  localparam int CntW = $clog2(GainW + 1);

  logic [DivDenW-1:0] rem_r;
  logic [DivDenW-1:0] rem_nxt;
  logic [DivDenW-1:0] den_r;
  logic [GainW-1:0]   qn_r;
  logic [CntW-1:0]    cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [DivDenW:0]   trial;
  logic [DivDenW:0]   diff;
  logic               fits;

  always_comb begin
    trial   = {rem_r, qn_r[GainW-1]};
    diff    = trial - {1'b0, den_r};
    fits    = (trial >= {1'b0, den_r});
    rem_nxt = fits ? diff[DivDenW-1:0] : trial[DivDenW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CntW'(GainW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, num[DivNumW-1:GainW]};
      qn_r  <= num[GainW-1:0];
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      qn_r  <= {qn_r[GainW-2:0], fits};
    end
  end

  assign quotient  = qn_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ----- hw/rtl/heading_kalman_filter_top.sv -----
// Top level of the scalar heading Kalman filter with serial arithmetic.
//
// Channel  Direction  Transfer when              Payload
// in_      input      in_tvalid & in_tready      tuser opcode, tdata item fields
// out_     output     out_tvalid & out_tready    tuser was_correction, tdata estimate
// cfg_     input      cfg_wr_en                  cfg_index, cfg_wr_data
//
// The work of an item runs through the 17-step serial multiplier, used twice per item, the
// 17-step gain divider on row items whose variance sum is not zero, and a four-step angle wrap.
// One item is in work at a time.
// Reset is synchronous and loads the register reset values into the estimate.
// A finished result waits in the output register while the next item is taken.
module heading_kalman_filter_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // yaw_rate, measured_angle, measure_variance, lateral_distance, zero fill
  input  logic [hkf_pkg::InDataW-1:0]  in_tdata,
  // opcode
  input  logic                         in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // heading_error, heading_variance, distance_out, zero fill
  output logic [hkf_pkg::OutDataW-1:0] out_tdata,
  // was_correction
  output logic                         out_tuser,
  input  logic                         cfg_wr_en,
  input  logic [hkf_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [hkf_pkg::CfgDataW-1:0] cfg_wr_data
);
  import hkf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MUL1,
    S_MUL2,
    S_WRAP,
    S_EMIT
  } state_t;

  state_t state_r;

  logic [TsW-1:0]     time_step_r;
  logic [NoiseW-1:0]  gyro_noise_r;
  logic [AngleW-1:0]  angle_r;
  logic [VarW-1:0]    var_r;
  logic [DistW-1:0]   dist_r;
  logic               op_r;
  logic               sign_r;
  logic [RateW-1:0]   mag_r;
  logic [GainW-1:0]   gain_r;
  logic [WrapW-1:0]   wrap_r;
  logic [1:0]         k_r;

  logic               mul_start_r;
  logic [MulAW-1:0]   mul_a_r;
  logic [MulBW-1:0]   mul_b_r;
  logic               div_start_r;
  logic [DivNumW-1:0] div_num_r;
  logic [DivDenW-1:0] div_den_r;

  logic               out_tvalid_r;
  logic               out_tuser_r;
  logic [AngleW-1:0]  out_err_r;
  logic [VarW-1:0]    out_var_r;
  logic [DistW-1:0]   out_dist_r;

  logic [MulPW-1:0]   mul_prod;
  unit_stat_t         mul_stat;
  logic [GainW-1:0]   div_q;
  unit_stat_t         div_stat;

  logic [RateW-1:0]   in_rate;
  logic [MeasW-1:0]   in_meas;
  logic [VarW-1:0]    in_mvar;
  logic [DistW-1:0]   in_dist;
  logic               in_xfer;

  logic [RateW-1:0]   rate_mag;
  logic [InnovW-1:0]  innov;
  logic [InnovW-1:0]  innov_mag;
  logic [DivDenW-1:0] var_sum;
  logic [DivNumW-1:0] gain_num;
  logic [GainW-1:0]   gain_sat;
  logic [MulPW-1:0]   rnd_full;
  logic [MulPW-FracW-1:0] rnd;
  logic [WrapW:0]     angle_base;
  logic [WrapW:0]     corr_ext;
  logic [WrapW:0]     angle_sum;
  logic [VarW:0]      var_grow;
  logic [VarW-1:0]    var_pred;
  logic [WrapW-1:0]   wrap_lim;
  logic [WrapW-1:0]   wrap_nxt;
  logic [AngleW-1:0]  cfg_angle;

  assign in_rate = in_tdata[RateW-1:0];
  assign in_meas = in_tdata[RateW+MeasW-1:RateW];
  assign in_mvar = in_tdata[RateW+MeasW+VarW-1:RateW+MeasW];
  assign in_dist = in_tdata[RateW+MeasW+VarW+DistW-1:RateW+MeasW+VarW];
  assign in_xfer = in_tvalid && in_tready;

  always_comb begin
    rate_mag   = in_rate[RateW-1] ? (~in_rate + 1'b1) : in_rate;
    innov      = {{(InnovW-MeasW){in_meas[MeasW-1]}}, in_meas}
               + InnovW'(AnglePi) - {{(InnovW-AngleW){1'b0}}, angle_r};
    innov_mag  = innov[InnovW-1] ? (~innov + 1'b1) : innov;
    var_sum    = {1'b0, var_r} + {1'b0, in_mvar};
    gain_num   = {1'b0, var_r, {FracW{1'b0}}}
               + {{(DivNumW-VarW){1'b0}}, var_sum[DivDenW-1:1]};
    gain_sat   = (div_q > GainOne) ? GainOne : div_q;
    rnd_full   = mul_prod + RoundHalf;
    rnd        = rnd_full[MulPW-1:FracW];
    angle_base = {{(WrapW+1-AngleW){1'b0}}, angle_r} + WrapBias;
    corr_ext   = {{(WrapW+1-RateW){1'b0}}, rnd[RateW-1:0]};
    angle_sum  = sign_r ? (angle_base - corr_ext) : (angle_base + corr_ext);
    var_grow   = {1'b0, var_r} + {{(VarW-NoiseW){1'b0}}, rnd[NoiseW:0]};
    var_pred   = var_grow[VarW] ? {VarW{1'b1}} : var_grow[VarW-1:0];
    wrap_lim   = {{(WrapW-AngleW){1'b0}}, AngleTwoPi} << k_r;
    wrap_nxt   = (wrap_r >= wrap_lim) ? (wrap_r - wrap_lim) : wrap_r;
    cfg_angle  = (cfg_wr_data[AngleW-1:0] >= AngleTwoPi)
               ? (cfg_wr_data[AngleW-1:0] - AngleTwoPi) : cfg_wr_data[AngleW-1:0];
  end

  hkf_serial_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start_r),
    .a       (mul_a_r),
    .b       (mul_b_r),
    .product (mul_prod),
    .stat    (mul_stat)
  );

  hkf_gain_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .num      (div_num_r),
    .den      (div_den_r),
    .quotient (div_q),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      time_step_r  <= ResetTimeStep;
      gyro_noise_r <= ResetGyroNoise;
      angle_r      <= ResetAngle;
      var_r        <= ResetVariance;
      dist_r       <= '0;
      mul_start_r  <= 1'b0;
      div_start_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
      if (out_tvalid_r && out_tready && (state_r != S_EMIT)) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            op_r <= in_tuser;
            if (in_tuser == OpGyro) begin
              sign_r      <= in_rate[RateW-1];
              mag_r       <= rate_mag;
              mul_a_r     <= MulAW'(rate_mag);
              mul_b_r     <= {1'b0, time_step_r};
              mul_start_r <= 1'b1;
              state_r     <= S_MUL1;
            end else begin
              dist_r <= in_dist;
              sign_r <= innov[InnovW-1];
              mag_r  <= innov_mag;
              if (var_sum == '0) begin
                gain_r      <= '0;
                mul_a_r     <= MulAW'(innov_mag);
                mul_b_r     <= '0;
                mul_start_r <= 1'b1;
                state_r     <= S_MUL1;
              end else begin
                div_num_r   <= gain_num;
                div_den_r   <= var_sum;
                div_start_r <= 1'b1;
                state_r     <= S_DIV;
              end
            end
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            gain_r      <= gain_sat;
            mul_a_r     <= MulAW'(mag_r);
            mul_b_r     <= gain_sat;
            mul_start_r <= 1'b1;
            state_r     <= S_MUL1;
          end
        end
        S_MUL1: begin
          if (mul_stat.done) begin
            wrap_r <= angle_sum[WrapW-1:0];
            if (op_r == OpGyro) begin
              mul_a_r <= MulAW'(gyro_noise_r);
              mul_b_r <= {1'b0, time_step_r};
            end else begin
              mul_a_r <= var_r;
              mul_b_r <= GainOne - gain_r;
            end
            mul_start_r <= 1'b1;
            state_r     <= S_MUL2;
          end
        end
        S_MUL2: begin
          if (mul_stat.done) begin
            var_r   <= (op_r == OpGyro) ? var_pred : rnd[VarW-1:0];
            k_r     <= 2'(WrapSteps - 1);
            state_r <= S_WRAP;
          end
        end
        S_WRAP: begin
          wrap_r <= wrap_nxt;
          if (k_r == '0) begin
            angle_r <= wrap_nxt[AngleW-1:0];
            state_r <= S_EMIT;
          end else begin
            k_r <= k_r - 1'b1;
          end
        end
        S_EMIT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tuser_r  <= op_r;
            out_err_r    <= angle_r - AnglePi;
            out_var_r    <= var_r;
            out_dist_r   <= dist_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (cfg_wr_en) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_TIME_STEP:  time_step_r  <= cfg_wr_data[TsW-1:0];
          CFG_GYRO_NOISE: gyro_noise_r <= cfg_wr_data[NoiseW-1:0];
          CFG_INIT_ANGLE: angle_r      <= cfg_angle;
          CFG_INIT_VAR:   var_r        <= cfg_wr_data[VarW-1:0];
        endcase
      end
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_tuser_r;
  assign out_tdata  = {{(OutDataW-AngleW-VarW-DistW){1'b0}}, out_dist_r, out_var_r, out_err_r};

endmodule

// ----- hw/rtl/hkf_checker.sv -----
// Port-level checker for the heading filter top level, bound to it.
module hkf_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic [hkf_pkg::InDataW-1:0]  in_tdata,
  input logic                         in_tuser,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [hkf_pkg::OutDataW-1:0] out_tdata,
  input logic                         out_tuser,
  input logic                         cfg_wr_en,
  input logic [hkf_pkg::CfgIdxW-1:0]  cfg_index,
  input logic [hkf_pkg::CfgDataW-1:0] cfg_wr_data
);
  import hkf_pkg::*;

  logic signed [AngleW-1:0] heading_err;

  assign heading_err = $signed(out_tdata[AngleW-1:0]);

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // After a transfer in, the block is busy for at least the next cycle.
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again right after a transfer");

  // A new result only appears straight after the input side was closed.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without work in progress");

  // The reported heading error stays within plus or minus pi.
  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (heading_err >= -19'sd205887) && (heading_err <= 19'sd205887))
    else $error("heading error outside of range");

endmodule

bind heading_kalman_filter_top hkf_checker u_hkf_checker (.*);

// ----- dv/heading_kalman_filter_top_test.sv -----
// Self-checking testbench for the heading Kalman filter: directed and random gyro and row items.
`timescale 1ns / 100ps

module heading_kalman_filter_top_test;
  import hkf_pkg::*;

  localparam longint PiQ = longint'(AnglePi);
  localparam longint TwoPiQ = longint'(AngleTwoPi);
  localparam longint unsigned GainOneQ = 64'd65536;
  localparam longint unsigned VarMaxQ = 64'hFFFF_FFFF;
  localparam int CycleLimit = 500000;
  localparam int HoldAtResult = 150;
  localparam int HoldCycles = 500;
  localparam int RandomPhases = 10;
  localparam int ItemsPerPhase = 53;
  localparam int DrainCycles = 120;

  typedef struct {
    logic               op;
    logic signed [21:0] rate;
    logic signed [18:0] meas;
    logic        [31:0] rvar;
    logic signed [23:0] distance;
  } heading_item_t;

  typedef struct {
    logic signed [18:0] err;
    logic        [31:0] variance;
    logic signed [23:0] distance;
    logic               corr;
  } heading_estimate_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;
  logic                in_tuser = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tuser;
  logic                cfg_wr_en = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wr_data = '0;

  heading_item_t     pending_items[$];
  heading_estimate_t expected_estimates[$];
  heading_item_t     offered;
  heading_estimate_t observed;
  heading_estimate_t wanted;

  logic        [15:0] time_step_q = ResetTimeStep;
  logic        [23:0] gyro_noise_q = ResetGyroNoise;
  longint             angle_est;
  longint unsigned    variance_est = ResetVariance;
  logic signed [23:0] held_dist = '0;

  int idle_pct = 20;
  int mismatches = 0;
  int results_seen = 0;
  int hold_left = 0;
  int cycle_count = 0;

  heading_kalman_filter_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  always #2 clk = ~clk;

  function automatic longint round_q16(longint p);
    longint mag;
    mag = (p < 0) ? -p : p;
    mag = (mag + 32768) >>> 16;
    return (p < 0) ? -mag : mag;
  endfunction

  function automatic longint wrap_angle(longint a);
    longint r;
    r = a % TwoPiQ;
    if (r < 0) begin
      r += TwoPiQ;
    end
    return r;
  endfunction

  function automatic heading_estimate_t kalman_update(heading_item_t it);
    heading_estimate_t est;
    longint            delta;
    longint            innov;
    longint unsigned   growth;
    longint unsigned   grown;
    longint unsigned   p;
    longint unsigned   s;
    longint unsigned   gain;
    if (it.op == OpGyro) begin
      delta = round_q16(longint'(it.rate) * longint'(time_step_q));
      growth = (longint'(gyro_noise_q) * longint'(time_step_q) + 32768) >> 16;
      grown = variance_est + growth;
      angle_est = wrap_angle(angle_est + delta);
      variance_est = (grown > VarMaxQ) ? VarMaxQ : grown;
    end else begin
      p = variance_est;
      s = p + longint'(it.rvar);
      gain = 0;
      if (s != 0) begin
        gain = ((p << 16) + (s >> 1)) / s;
      end
      if (gain > GainOneQ) begin
        gain = GainOneQ;
      end
      innov = longint'(it.meas) + PiQ - angle_est;
      angle_est = wrap_angle(angle_est + round_q16(longint'(gain) * innov));
      variance_est = (p * (GainOneQ - gain) + 32768) >> 16;
      held_dist = it.distance;
    end
    est.err = 19'(angle_est - PiQ);
    est.variance = variance_est[31:0];
    est.distance = held_dist;
    est.corr = it.op;
    return est;
  endfunction

  function automatic heading_item_t mk(logic op, int rate, int meas, logic [31:0] rvar,
                                       int distance);
    heading_item_t it;
    it.op = op;
    it.rate = 22'(rate);
    it.meas = 19'(meas);
    it.rvar = rvar;
    it.distance = 24'(distance);
    return it;
  endfunction

  function automatic heading_item_t random_item();
    heading_item_t it;
    it.op = 1'($urandom_range(1));
    if ($urandom_range(3) == 0) begin
      it.rate = 22'($urandom);
    end else begin
      it.rate = 22'(int'($urandom_range(131072)) - 65536);
    end
    it.meas = 19'($urandom);
    case ($urandom_range(5))
      0: it.rvar = '0;
      1: it.rvar = 32'hFFFF_FFFF;
      2: it.rvar = $urandom;
      default: it.rvar = $urandom_range(1 << 24);
    endcase
    it.distance = 24'($urandom);
    return it;
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= value;
    case (idx)
      CFG_TIME_STEP: time_step_q = value[15:0];
      CFG_GYRO_NOISE: gyro_noise_q = value[23:0];
      CFG_INIT_ANGLE: angle_est = wrap_angle(longint'(value[18:0]));
      CFG_INIT_VAR: variance_est = value;
      default: ;
    endcase
  endtask

  task automatic write_settings(logic [31:0] ts, logic [31:0] noise, logic [31:0] ang,
                                logic [31:0] variance);
    write_reg(CFG_TIME_STEP, ts);
    write_reg(CFG_GYRO_NOISE, noise);
    write_reg(CFG_INIT_ANGLE, ang);
    write_reg(CFG_INIT_VAR, variance);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Sampled on the falling edge so that every transfer of the rising edge has settled.
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (pending_items.size() != 0 || in_tvalid || expected_estimates.size() != 0);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_estimates.push_back(kalman_update(offered));
      end
      if (!in_tvalid || in_tready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
          offered = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {7'd0, offered.distance, offered.rvar, offered.meas, offered.rate};
          in_tuser <= offered.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        observed.err = out_tdata[18:0];
        observed.variance = out_tdata[50:19];
        observed.distance = out_tdata[74:51];
        observed.corr = out_tuser;
        if (expected_estimates.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result err=%0d var=%0d dist=%0d corr=%0b", $time,
                   observed.err, observed.variance, observed.distance, observed.corr);
        end else begin
          wanted = expected_estimates.pop_front();
          if (observed.err !== wanted.err || observed.variance !== wanted.variance ||
              observed.distance !== wanted.distance || observed.corr !== wanted.corr) begin
            mismatches++;
            $display("%0t: expected err=%0d var=%0d dist=%0d corr=%0b", $time,
                     wanted.err, wanted.variance, wanted.distance, wanted.corr);
            $display("%0t: actual   err=%0d var=%0d dist=%0d corr=%0b", $time,
                     observed.err, observed.variance, observed.distance, observed.corr);
          end
        end
        results_seen++;
        if (results_seen == HoldAtResult) begin
          hold_left = HoldCycles;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    angle_est = wrap_angle(longint'(ResetAngle));
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    pending_items.push_back(mk(OpGyro, 0, 0, 0, 0));
    pending_items.push_back(mk(OpGyro, 2097151, 0, 0, 0));
    pending_items.push_back(mk(OpGyro, -2097152, 0, 0, 0));
    pending_items.push_back(mk(OpGyro, 1, 0, 0, 0));
    pending_items.push_back(mk(OpGyro, -1, 0, 0, 0));
    pending_items.push_back(mk(OpRow, 0, 262143, 1000000, 8388607));
    pending_items.push_back(mk(OpRow, 0, -262144, 32'hFFFF_FFFF, -8388608));
    pending_items.push_back(mk(OpRow, 0, 0, 0, 0));
    pending_items.push_back(mk(OpRow, 0, 205887, 5000000, 12345));
    pending_items.push_back(mk(OpRow, 0, -205887, 1, -1));
    wait_drained();

    write_settings(32'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    pending_items.push_back(mk(OpGyro, 2097151, 0, 0, 0));
    pending_items.push_back(mk(OpGyro, -2097152, 0, 0, 0));
    pending_items.push_back(mk(OpRow, 0, 262143, 0, 4096));
    pending_items.push_back(mk(OpGyro, 0, 0, 0, 0));
    pending_items.push_back(mk(OpRow, 0, -262144, 32'hFFFF_FFFF, -4096));
    wait_drained();

    write_settings(1, 0, 0, 0);
    pending_items.push_back(mk(OpRow, 0, 100, 0, 77));
    pending_items.push_back(mk(OpGyro, -1, 0, 0, 0));
    pending_items.push_back(mk(OpRow, 0, 262143, 0, -77));
    pending_items.push_back(mk(OpGyro, 2097151, 0, 0, 0));
    pending_items.push_back(mk(OpRow, 0, -1000, 1, 0));
    wait_drained();

    for (int ph = 0; ph < RandomPhases; ph++) begin
      idle_pct = (ph == 4) ? 0 : 20;
      case ($urandom_range(3))
        0: write_settings(1, $urandom, $urandom, 0);
        1: write_settings(32'hFFFF, $urandom, $urandom, 32'hFFFF_FFFF);
        2: write_settings(ResetTimeStep, ResetGyroNoise, ResetAngle, ResetVariance);
        default: write_settings($urandom_range(4000, 1), $urandom, $urandom,
                                $urandom_range(1 << 26));
      endcase
      for (int n = 0; n < ItemsPerPhase; n++) begin
        pending_items.push_back(random_item());
      end
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && expected_estimates.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
